FILE: rtl/lphs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lphs_pkg: shared types for the linear probing hash set
// Field widths and result status codes.
// ----------------------------------------------------------------------------
package lphs_pkg;

	localparam int KEY_W    = 64;
	localparam int SLOT_W   = 10;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 11;
	localparam int SUM_W    = 11;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_INSERTED = 2'd0,
		STATUS_PRESENT  = 2'd1,
		STATUS_FULL     = 2'd2
	} status_t;

endpackage
`default_nettype wire

FILE: rtl/linear_probe_hash_set_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_set_core: byte-sum hashed set with linear probing
// Each of the P slots probed (1..N) takes a read of the key memory in
// S_PROBE and a compare in S_CHECK; a new item is accepted only in S_IDLE,
// once the result for the previous item is done.
// Reset: valid bits are cleared by a sweep over all TABLE_ENTRIES slots after
// arst_n releases; busy stays high during the sweep. Results cannot be stalled.
// ----------------------------------------------------------------------------
module linear_probe_hash_set_core
	import lphs_pkg::*;
#(
	parameter int TABLE_ENTRIES = 1024,
	parameter int KEY_BYTES     = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [KEY_W-1:0]    key_bytes,
	output logic                     done,
	output logic [SLOT_W-1:0]        slot_index,
	output logic [STATUS_W-1:0]      status,
	output logic [TOTAL_W-1:0]       entry_total
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_ENTRIES - 1);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_PROBE,
		S_CHECK
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    clr_q;
	logic [AW-1:0]    slot_q;
	logic [AW-1:0]    home_q;
	logic [AW-1:0]    probe_q;
	logic [KEY_W-1:0] key_q;
	logic [CW-1:0]    count_q;
	logic             done_q;
	logic [SLOT_W-1:0]  slot_out_q;
	status_t          status_q;
	logic [TOTAL_W-1:0] total_q;

	logic [KEY_W:0]   key_mem [TABLE_ENTRIES];
	logic [KEY_W:0]   rdata_q;

	logic [KEY_W-1:0] key_c;
	logic [SUM_W-1:0] sum_c;
	logic             live;

	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	logic [KEY_W:0]   mem_wd;

	logic             hit;

	// key ends at first zero byte or at KEY_BYTES
	always_comb begin
		key_c = '0;
		sum_c = '0;
		live  = 1'b1;
		for (int i = 0; i < KEY_W / 8; i++) begin
			if (i >= KEY_BYTES || key_bytes[8*i +: 8] == 8'd0) begin
				live = 1'b0;
			end
			if (live) begin
				key_c[8*i +: 8] = key_bytes[8*i +: 8];
				sum_c = sum_c + SUM_W'(key_bytes[8*i +: 8]);
			end
		end
	end

	assign hit = rdata_q[KEY_W] && (rdata_q[KEY_W-1:0] == key_q);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = slot_q;
		mem_wd = {1'b1, key_q};
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (state_q == S_CHECK && !rdata_q[KEY_W]) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[mem_wa] <= mem_wd;
		end
		rdata_q <= key_mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SLOT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						key_q   <= key_c;
						home_q  <= AW'(sum_c);
						slot_q  <= AW'(sum_c);
						probe_q <= '0;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					priority if (!rdata_q[KEY_W]) begin
						count_q    <= count_q + 1'b1;
						slot_out_q <= SLOT_W'(slot_q);
						status_q   <= STATUS_INSERTED;
						total_q    <= TOTAL_W'(count_q + 1'b1);
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else if (hit) begin
						slot_out_q <= SLOT_W'(slot_q);
						status_q   <= STATUS_PRESENT;
						total_q    <= TOTAL_W'(count_q);
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else if (probe_q == LAST_SLOT) begin
						slot_out_q <= SLOT_W'(home_q);
						status_q   <= STATUS_FULL;
						total_q    <= TOTAL_W'(count_q);
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else begin
						slot_q  <= slot_q + 1'b1;
						probe_q <= probe_q + 1'b1;
						state_q <= S_PROBE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign slot_index  = slot_out_q;
	assign status      = status_q;
	assign entry_total = total_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not make the block busy");

	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("more than one result for an item");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		done && status_q == STATUS_INSERTED |-> count_q == $past(count_q) + 1'b1)
		else $error("insert without count increment");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status_q == STATUS_FULL |-> count_q == CW'(TABLE_ENTRIES))
		else $error("table full reported with free slots");

endmodule
`default_nettype wire
